### rtl/mfdr_pkg.sv
// Shared types and constants for the dense residual max-flow block.
`timescale 1ns / 1ps
package mfdr_pkg;

	localparam int NODE_BITS = 6;
	localparam int CAP_BITS  = 16;
	localparam int FLOW_BITS = 32;
	localparam int CFG_BITS  = 7;

	typedef enum logic [1:0] {
		CFG_NODE_COUNT  = 2'd0,
		CFG_SOURCE_NODE = 2'd1,
		CFG_SINK_NODE   = 2'd2
	} cfg_index_t;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [NODE_BITS-1:0] from_node;
		logic [NODE_BITS-1:0] to_node;
		logic [CAP_BITS-1:0]  edge_capacity;
		logic                 last_edge;
	} edge_item_t;

	typedef struct packed {
		logic [FLOW_BITS-1:0] flow_total;
		logic                 status;
	} result_t;

endpackage

### rtl/max_flow_dense_residual.sv
// Edmonds-Karp max flow over a dense residual matrix held in a synchronous memory.
// Edge load: one item per cycle while idle, as a registered read-modify-write with forwarding.
// After the last edge a drain state checks the configuration; then each search seeds the queue,
// scans the row of each dequeued node until the sink, walks parents for the bottleneck, augments.
// An error request passes the drain and result states before done; done is a one-cycle strobe.
// After reset and after each result a clearing pass writes NODES*NODES cells, one per cycle.
`timescale 1ns / 1ps
module max_flow_dense_residual
	import mfdr_pkg::*;
#(
	parameter int NODES     = 64,
	parameter int CELL_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  edge_item_t          edge_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output logic                done,
	output result_t             result
);

	localparam int IDX   = $clog2(NODES);
	localparam int CW    = $clog2(NODES + 1);
	localparam int CELLS = NODES * NODES;
	localparam int AW    = $clog2(CELLS);
	localparam int FW    = ((CELL_BITS > FLOW_BITS) ? CELL_BITS : FLOW_BITS) + 1;
	localparam logic [CELL_BITS-1:0] CELL_MAX = '1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DRAIN, S_BS, S_QRD, S_QW, S_SCAN,
		S_NKP, S_NKPW, S_NKM, S_AUP, S_AUPW, S_AUF, S_AUR, S_RES
	} state_t;

	state_t state_q;

	logic [CFG_BITS-1:0]  node_count_q;
	logic [NODE_BITS-1:0] source_q, sink_q;

	logic [CELL_BITS-1:0] mat_mem [CELLS];
	logic [IDX-1:0]       parent_mem [NODES];
	logic [IDX-1:0]       queue_mem [NODES];
	logic [NODES-1:0]     seen_q;

	logic [CELL_BITS-1:0] mat_rd;
	logic [IDX-1:0]       p_rd, q_rd;

	logic                 mat_we, q_we;
	logic [AW-1:0]        mat_wa, mat_ra;
	logic [CELL_BITS-1:0] mat_wd;
	logic [IDX-1:0]       q_wa, q_wd;

	// load pipeline
	logic                 ld_s1;
	logic [AW-1:0]        addr_s1;
	logic [CAP_BITS-1:0]  cap_s1;
	logic                 fwd_v_q;
	logic [AW-1:0]        fwd_addr_q;
	logic [CELL_BITS-1:0] fwd_val_q;

	logic [AW-1:0]        clr_q;
	logic [CW-1:0]        head_q, tail_q, sv_q;
	logic                 chk_s1;
	logic [IDX-1:0]       vs1_s1, u_q, pv_q, p_q;
	logic [CELL_BITS-1:0] neck_q;
	logic [FLOW_BITS-1:0] flow_q;
	logic                 done_q;
	result_t              result_q;

	logic [CW-1:0]        n_eff;
	logic                 ld_ok, accept, take, bad;
	logic [AW-1:0]        ld_addr;
	logic [CELL_BITS-1:0] ld_base;
	logic [CELL_BITS:0]   ld_sum, rev_sum;
	logic [CELL_BITS-1:0] ld_new;
	logic [FW-1:0]        flow_sum;
	logic [IDX-1:0]       src_i, snk_i;

	function automatic logic [AW-1:0] cell_addr(input logic [IDX-1:0] r, input logic [IDX-1:0] c);
		cell_addr = AW'(int'(r) * NODES + int'(c));
	endfunction

	assign n_eff   = (int'(node_count_q) > NODES) ? CW'(NODES) : CW'(node_count_q);
	assign accept  = start && !busy;
	assign ld_ok   = (edge_item.from_node != edge_item.to_node)
		&& (int'(edge_item.from_node) < int'(n_eff)) && (int'(edge_item.to_node) < int'(n_eff));
	assign ld_addr = cell_addr(IDX'(edge_item.from_node), IDX'(edge_item.to_node));
	assign ld_base = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_val_q : mat_rd;
	assign ld_sum  = {1'b0, ld_base} + (CELL_BITS+1)'(cap_s1);
	assign ld_new  = ld_sum[CELL_BITS] ? CELL_MAX : ld_sum[CELL_BITS-1:0];
	assign rev_sum = {1'b0, mat_rd} + {1'b0, neck_q};
	assign flow_sum = FW'(flow_q) + FW'(neck_q);
	assign take    = chk_s1 && !seen_q[vs1_s1] && (mat_rd != '0) && (int'(tail_q) < NODES);
	assign src_i   = IDX'(source_q);
	assign snk_i   = IDX'(sink_q);
	assign bad     = (n_eff == '0) || (source_q == sink_q)
		|| (int'(source_q) >= int'(n_eff)) || (int'(sink_q) >= int'(n_eff));

	always_comb begin
		mat_we = 1'b0;
		mat_wa = addr_s1;
		mat_wd = ld_new;
		mat_ra = ld_addr;
		q_we   = 1'b0;
		q_wa   = tail_q[IDX-1:0];
		q_wd   = vs1_s1;
		if (ld_s1) begin
			mat_we = 1'b1;
		end
		unique case (state_q) inside
			S_CLR: begin
				mat_we = 1'b1;
				mat_wa = clr_q;
				mat_wd = '0;
			end
			S_BS: begin
				q_we = 1'b1;
				q_wa = '0;
				q_wd = src_i;
			end
			S_SCAN: begin
				mat_ra = cell_addr(u_q, sv_q[IDX-1:0]);
				q_we   = take;
			end
			S_NKPW, S_AUPW: mat_ra = cell_addr(p_rd, pv_q);
			S_AUF: begin
				mat_we = 1'b1;
				mat_wa = cell_addr(p_q, pv_q);
				mat_wd = mat_rd - neck_q;
				mat_ra = cell_addr(pv_q, p_q);
			end
			S_AUR: begin
				mat_we = 1'b1;
				mat_wa = cell_addr(pv_q, p_q);
				mat_wd = rev_sum[CELL_BITS] ? CELL_MAX : rev_sum[CELL_BITS-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_wa] <= mat_wd;
		end
		mat_rd <= mat_mem[mat_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && take) begin
			parent_mem[vs1_s1] <= u_q;
		end
		p_rd <= parent_mem[pv_q];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_wa] <= q_wd;
		end
		q_rd <= queue_mem[head_q[IDX-1:0]];
	end

	always_ff @(posedge clk) begin
		addr_s1    <= ld_addr;
		cap_s1     <= edge_item.edge_capacity;
		fwd_addr_q <= addr_s1;
		fwd_val_q  <= ld_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			source_q     <= '0;
			sink_q       <= NODE_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_COUNT:  node_count_q <= cfg_data;
				CFG_SOURCE_NODE: source_q     <= cfg_data[NODE_BITS-1:0];
				CFG_SINK_NODE:   sink_q       <= cfg_data[NODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			ld_s1    <= 1'b0;
			fwd_v_q  <= 1'b0;
			seen_q   <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			sv_q     <= '0;
			chk_s1   <= 1'b0;
			vs1_s1   <= '0;
			u_q      <= '0;
			pv_q     <= '0;
			p_q      <= '0;
			neck_q   <= '0;
			flow_q   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			ld_s1   <= accept && ld_ok;
			fwd_v_q <= ld_s1;
			done_q  <= (state_q == S_RES);
			unique case (state_q)
				S_CLR: begin
					if (int'(clr_q) == CELLS - 1) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept && edge_item.last_edge) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					flow_q <= '0;
					if (bad) begin
						result_q <= '{flow_total: '0, status: STATUS_ERR};
						state_q  <= S_RES;
					end else begin
						state_q <= S_BS;
					end
				end
				S_BS: begin
					seen_q  <= NODES'(1) << src_i;
					head_q  <= '0;
					tail_q  <= CW'(1);
					state_q <= S_QRD;
				end
				S_QRD: begin
					if (head_q == tail_q) begin
						result_q <= '{flow_total: flow_q, status: STATUS_OK};
						state_q  <= S_RES;
					end else begin
						head_q  <= head_q + CW'(1);
						state_q <= S_QW;
					end
				end
				S_QW: begin
					u_q <= q_rd;
					if (q_rd == snk_i) begin
						pv_q    <= snk_i;
						neck_q  <= CELL_MAX;
						state_q <= S_NKP;
					end else begin
						sv_q    <= '0;
						chk_s1  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one cell read, check the one returned from last cycle
					if (take) begin
						seen_q[vs1_s1] <= 1'b1;
						tail_q         <= tail_q + CW'(1);
					end
					if (sv_q < n_eff) begin
						chk_s1 <= 1'b1;
						vs1_s1 <= sv_q[IDX-1:0];
						sv_q   <= sv_q + CW'(1);
					end else begin
						chk_s1 <= 1'b0;
						if (!chk_s1) begin
							state_q <= S_QRD;
						end
					end
				end
				S_NKP: begin
					if (pv_q == src_i) begin
						if (neck_q == '0) begin
							result_q <= '{flow_total: flow_q, status: STATUS_OK};
							state_q  <= S_RES;
						end else begin
							pv_q    <= snk_i;
							state_q <= S_AUP;
						end
					end else begin
						state_q <= S_NKPW;
					end
				end
				S_NKPW: begin
					p_q     <= p_rd;
					state_q <= S_NKM;
				end
				S_NKM: begin
					if (mat_rd < neck_q) begin
						neck_q <= mat_rd;
					end
					pv_q    <= p_q;
					state_q <= S_NKP;
				end
				S_AUP: begin
					if (pv_q == src_i) begin
						flow_q  <= (flow_sum > FW'({FLOW_BITS{1'b1}})) ? '1
							: flow_sum[FLOW_BITS-1:0];
						state_q <= S_BS;
					end else begin
						state_q <= S_AUPW;
					end
				end
				S_AUPW: begin
					p_q     <= p_rd;
					state_q <= S_AUF;
				end
				S_AUF: state_q <= S_AUR;
				S_AUR: begin
					pv_q    <= p_q;
					state_q <= S_AUP;
				end
				S_RES: begin
					clr_q   <= '0;
					state_q <= S_CLR;
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

### rtl/mfdr_checker.sv
// Port-level checks for the max-flow block, bound into max_flow_dense_residual.
`timescale 1ns / 1ps
module mfdr_checker
	import mfdr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input edge_item_t edge_item,
	input logic       done,
	input result_t    result
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STATUS_ERR) |-> (result.flow_total == '0))
		else $error("error result with nonzero flow");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !edge_item.last_edge) |=> !busy)
		else $error("plain edge item made block busy");

endmodule

bind max_flow_dense_residual mfdr_checker u_mfdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.edge_item (edge_item),
	.done      (done),
	.result    (result)
);
